>>> rtl/shortest_path_finder_core_macros.svh
// assertion macros for the shortest path finder core
`ifndef SHORTEST_PATH_FINDER_CORE_MACROS_SVH
`define SHORTEST_PATH_FINDER_CORE_MACROS_SVH

// checked at every edge outside reset
`define SPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define SPF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/spf_pkg.sv
// types and constants of the shortest path finder core
`timescale 1ns / 1ps

package spf_pkg;

    localparam int NODE_FIELD_BITS   = 7;
    localparam int WEIGHT_FIELD_BITS = 20;
    localparam int CFG_BITS          = 7;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef enum logic [12:0] {
        ST_CLEAR     = 13'b0000000000001,
        ST_IDLE      = 13'b0000000000010,
        ST_ADD_RD    = 13'b0000000000100,
        ST_ADD_CMP   = 13'b0000000001000,
        ST_ADD_WR2   = 13'b0000000010000,
        ST_INIT      = 13'b0000000100000,
        ST_SCAN      = 13'b0000001000000,
        ST_RELAX     = 13'b0000010000000,
        ST_PATH      = 13'b0000100000000,
        ST_WALK      = 13'b0001000000000,
        ST_WALK_WAIT = 13'b0010000000000,
        ST_EMIT_RD   = 13'b0100000000000,
        ST_EMIT_LD   = 13'b1000000000000
    } state_t;

endpackage

>>> rtl/shortest_path_finder_core.sv
// shortest path finder core: adjacency matrix with a sequential dijkstra search
`timescale 1ns / 1ps
`include "shortest_path_finder_core_macros.svh"

// Edges go into an adjacency matrix held in one RAM; an add-edge item reads, compares
// and, if the new weight wins, does two writes, and gives no result. A find item runs Dijkstra
// from node 1 with one shared add/compare unit: each round scans the n active nodes
// for the nearest unsettled one and then relaxes its matrix row; after the search
// it walks the predecessors and emits one result per path node. Each find then
// clears the matrix, one entry per cycle; the same clearing pass runs after reset
// before the first item is taken. Configuration writes are accepted at any time.
module shortest_path_finder_core
    import spf_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 20
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_BITS-1:0]          cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [NODE_FIELD_BITS-1:0]   s_edge_from,
    input  logic [NODE_FIELD_BITS-1:0]   s_edge_to,
    input  logic [WEIGHT_FIELD_BITS-1:0] s_edge_weight,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [NODE_FIELD_BITS-1:0]   m_path_node,
    output logic                         m_path_last,
    output logic                         m_no_path
);

    localparam int NB     = $clog2(MAX_NODES);
    localparam int DB     = WEIGHT_BITS + NB;
    localparam int NDEPTH = 1 << NB;
    localparam int ADEPTH = 1 << (2 * NB);

    state_t state_reg, state_next;
    logic [CFG_BITS-1:0]  node_count_reg;
    logic [NB:0]          cnt_reg, cnt_next;
    logic                 pv_reg, pv_next;
    logic [NB-1:0]        pidx_reg, pidx_next;
    logic                 found_reg, found_next;
    logic [NB-1:0]        bestu_reg, bestu_next;
    logic [DB-1:0]        bestd_reg, bestd_next;
    logic [MAX_NODES-1:0] reached_reg, reached_next;
    logic [MAX_NODES-1:0] settled_reg, settled_next;
    logic [MAX_NODES-1:0] pvalid_reg, pvalid_next;
    logic [NB-1:0]        ea_reg, ea_next, eb_reg, eb_next;
    logic [WEIGHT_BITS-1:0] ew_reg, ew_next;
    logic [2*NB-1:0]      clr_reg, clr_next;
    logic [NB-1:0]        k_reg, k_next;
    logic [NB:0]          count_reg, count_next;
    logic [NB-1:0]        e_reg, e_next;
    logic                 nopath_reg, nopath_next;
    logic                 m_valid_reg, m_valid_next;
    logic [NODE_FIELD_BITS-1:0] m_node_reg, m_node_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_nopath_reg, m_nopath_next;

    // memories and their read data
    logic [WEIGHT_BITS:0] adj_mem [0:ADEPTH-1];
    logic [DB-1:0]        dist_mem [0:NDEPTH-1];
    logic [NB-1:0]        prev_mem [0:NDEPTH-1];
    logic [NB-1:0]        chain_mem [0:NDEPTH-1];
    logic [WEIGHT_BITS:0] adj_rd_reg;
    logic [DB-1:0]        dist_rd_reg;
    logic [NB-1:0]        prev_rd_reg;
    logic [NB-1:0]        chain_rd_reg;

    logic                 adj_we;
    logic [2*NB-1:0]      adj_wa, adj_ra;
    logic [WEIGHT_BITS:0] adj_wd;
    logic                 dist_we;
    logic [NB-1:0]        dist_wa, dist_ra;
    logic [DB-1:0]        dist_wd;
    logic                 prev_we;
    logic                 chain_we;
    logic [NB-1:0]        chain_wa;
    logic [NB-1:0]        chain_wd;

    logic [NB:0]          nact;
    logic [NB-1:0]        last_node;
    logic                 in_range;
    logic [DB-1:0]        alt;
    logic                 s_accept;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_path_node = m_node_reg;
    assign m_path_last = m_last_reg;
    assign m_no_path   = m_nopath_reg;

    // active node count, out of range values saturate
    always_comb begin
        if (node_count_reg == '0) begin
            nact = (NB+1)'(1);
        end else if (node_count_reg > CFG_BITS'(MAX_NODES)) begin
            nact = (NB+1)'(MAX_NODES);
        end else begin
            nact = (NB+1)'(node_count_reg);
        end
    end

    assign last_node = NB'(nact - (NB+1)'(1));
    assign in_range  = (s_edge_from != '0) && (s_edge_to != '0)
                    && (s_edge_from <= NODE_FIELD_BITS'(nact))
                    && (s_edge_to <= NODE_FIELD_BITS'(nact));
    assign alt       = bestd_reg + DB'(adj_rd_reg[WEIGHT_BITS-1:0]);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pv_next       = pv_reg;
        pidx_next     = pidx_reg;
        found_next    = found_reg;
        bestu_next    = bestu_reg;
        bestd_next    = bestd_reg;
        reached_next  = reached_reg;
        settled_next  = settled_reg;
        pvalid_next   = pvalid_reg;
        ea_next       = ea_reg;
        eb_next       = eb_reg;
        ew_next       = ew_reg;
        clr_next      = clr_reg;
        k_next        = k_reg;
        count_next    = count_reg;
        e_next        = e_reg;
        nopath_next   = nopath_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_node_next   = m_node_reg;
        m_last_next   = m_last_reg;
        m_nopath_next = m_nopath_reg;

        adj_we   = 1'b0;
        adj_wa   = {ea_reg, eb_reg};
        adj_wd   = {1'b1, ew_reg};
        adj_ra   = {ea_reg, eb_reg};
        dist_we  = 1'b0;
        dist_wa  = pidx_reg;
        dist_wd  = alt;
        dist_ra  = cnt_reg[NB-1:0];
        prev_we  = 1'b0;
        chain_we = 1'b0;
        chain_wa = count_reg[NB-1:0];
        chain_wd = prev_rd_reg;

        case (state_reg)
            ST_CLEAR: begin
                adj_we   = 1'b1;
                adj_wa   = clr_reg;
                adj_wd   = '0;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_op == OP_FIND) begin
                        state_next = ST_INIT;
                    end else if (in_range) begin
                        ea_next    = NB'(s_edge_from - NODE_FIELD_BITS'(1));
                        eb_next    = NB'(s_edge_to - NODE_FIELD_BITS'(1));
                        ew_next    = WEIGHT_BITS'(s_edge_weight);
                        state_next = ST_ADD_RD;
                    end
                end
            end
            ST_ADD_RD: begin
                state_next = ST_ADD_CMP;
            end
            ST_ADD_CMP: begin
                // the matrix stays symmetric, so one entry decides both writes
                if (!adj_rd_reg[WEIGHT_BITS] || (ew_reg < adj_rd_reg[WEIGHT_BITS-1:0])) begin
                    adj_we     = 1'b1;
                    state_next = ST_ADD_WR2;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_WR2: begin
                adj_we     = 1'b1;
                adj_wa     = {eb_reg, ea_reg};
                state_next = ST_IDLE;
            end
            ST_INIT: begin
                reached_next    = '0;
                reached_next[0] = 1'b1;
                settled_next    = '0;
                pvalid_next     = '0;
                dist_we         = 1'b1;
                dist_wa         = '0;
                dist_wd         = '0;
                cnt_next        = '0;
                pv_next         = 1'b0;
                found_next      = 1'b0;
                state_next      = ST_SCAN;
            end
            ST_SCAN: begin
                // nearest reached unsettled node, lowest index wins a tie
                if (pv_reg && reached_reg[pidx_reg] && !settled_reg[pidx_reg]
                        && (!found_reg || (dist_rd_reg < bestd_reg))) begin
                    found_next = 1'b1;
                    bestu_next = pidx_reg;
                    bestd_next = dist_rd_reg;
                end
                if (cnt_reg < nact) begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[NB-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end else begin
                    pv_next = 1'b0;
                    if (!pv_reg) begin
                        if (!found_reg || (bestu_reg == last_node)) begin
                            state_next = ST_PATH;
                        end else begin
                            settled_next[bestu_reg] = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_RELAX;
                        end
                    end
                end
            end
            ST_RELAX: begin
                adj_ra = {bestu_reg, cnt_reg[NB-1:0]};
                if (pv_reg && adj_rd_reg[WEIGHT_BITS]
                        && (!reached_reg[pidx_reg] || (alt < dist_rd_reg))) begin
                    dist_we               = 1'b1;
                    prev_we               = 1'b1;
                    reached_next[pidx_reg] = 1'b1;
                    pvalid_next[pidx_reg]  = 1'b1;
                end
                if (cnt_reg < nact) begin
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[NB-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end else begin
                    pv_next = 1'b0;
                    if (!pv_reg) begin
                        cnt_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_PATH: begin
                if (!pvalid_reg[last_node]) begin
                    nopath_next = 1'b1;
                    state_next  = ST_EMIT_LD;
                end else begin
                    nopath_next = 1'b0;
                    chain_we    = 1'b1;
                    chain_wa    = '0;
                    chain_wd    = last_node;
                    k_next      = last_node;
                    count_next  = (NB+1)'(1);
                    state_next  = ST_WALK;
                end
            end
            ST_WALK: begin
                if (pvalid_reg[k_reg] && (count_reg < (NB+1)'(MAX_NODES))) begin
                    state_next = ST_WALK_WAIT;
                end else begin
                    e_next     = NB'(count_reg - (NB+1)'(1));
                    state_next = ST_EMIT_RD;
                end
            end
            ST_WALK_WAIT: begin
                chain_we   = 1'b1;
                k_next     = prev_rd_reg;
                count_next = count_reg + 1'b1;
                state_next = ST_WALK;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                // wait until the output register is free
                if (!m_valid_reg) begin
                    m_valid_next  = 1'b1;
                    m_nopath_next = nopath_reg;
                    m_last_next   = nopath_reg || (e_reg == '0);
                    m_node_next   = nopath_reg ? '0
                                  : NODE_FIELD_BITS'(chain_rd_reg) + NODE_FIELD_BITS'(1);
                    if (nopath_reg || (e_reg == '0)) begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        e_next     = e_reg - 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            node_count_reg <= CFG_BITS'(64);
            pv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            reached_reg    <= '0;
            settled_reg    <= '0;
            pvalid_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pv_reg      <= pv_next;
            found_reg   <= found_next;
            reached_reg <= reached_next;
            settled_reg <= settled_next;
            pvalid_reg  <= pvalid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        pidx_reg     <= pidx_next;
        bestu_reg    <= bestu_next;
        bestd_reg    <= bestd_next;
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        ew_reg       <= ew_next;
        k_reg        <= k_next;
        count_reg    <= count_next;
        e_reg        <= e_next;
        nopath_reg   <= nopath_next;
        m_node_reg   <= m_node_next;
        m_last_reg   <= m_last_next;
        m_nopath_reg <= m_nopath_next;
    end

    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[adj_wa] <= adj_wd;
        end
        adj_rd_reg <= adj_mem[adj_ra];
    end

    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[dist_wa] <= dist_wd;
        end
        dist_rd_reg <= dist_mem[dist_ra];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[pidx_reg] <= bestu_reg;
        end
        prev_rd_reg <= prev_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (chain_we) begin
            chain_mem[chain_wa] <= chain_wd;
        end
        chain_rd_reg <= chain_mem[e_reg];
    end

    `SPF_ASSERT(a_out_from_emit, $rose(m_valid) |-> $past(state_reg) == ST_EMIT_LD, "result raised outside emit")
    `SPF_ASSERT(a_no_path_last, m_valid && m_no_path |-> m_path_last, "no_path result not marked last")
    `SPF_ASSERT(a_find_busy, s_valid && s_ready && (s_op == OP_FIND) |=> !s_ready, "ready right after a find")
    `SPF_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> (state_reg == ST_CLEAR) && !m_valid, "reset did not start clearing")

endmodule
